### rtl/core/rrpcd_pkg.sv
// Package of the remote pulse code decoder: payload structs, codes, constants.
// Shared by the front, the queues, the back end and the top level. No dependencies.
`default_nettype none

package rrpcd_pkg;

  // Fixed field widths.
  localparam int unsigned CountW  = 24;  // measured width in 16 ns counts
  localparam int unsigned UsW     = 19;  // width in us before range check
  localparam int unsigned CfgW    = 16;  // widest register
  localparam int unsigned RatioW  = 8;
  localparam int unsigned ProdW   = CfgW + RatioW;
  localparam int unsigned CodeW   = 24;
  localparam int unsigned NumW    = 32;
  localparam int unsigned BitsW   = 5;

  // floor(count * 16 / 1000) == ((2 * count) * RecipUs) >> RecipShift, exact for
  // every 24-bit count (the rounding excess of the reciprocal stays below one).
  localparam int unsigned RecipShift = 32;
  localparam logic [25:0] RecipUs    = 26'h20C49BB;

  // Register reset values.
  localparam logic [CfgW-1:0]   MinWidthRst = 16'd150;
  localparam logic [CfgW-1:0]   MaxWidthRst = 16'd4500;
  localparam logic [RatioW-1:0] SyncMinRst  = 8'd25;
  localparam logic [RatioW-1:0] SyncMaxRst  = 8'd40;

  localparam int unsigned FrameBitsDefault = 24;

  // Queue depths.
  localparam int unsigned TokDepth = 2;
  localparam int unsigned ResDepth = 4;

  typedef enum logic [1:0] {
    REG_MIN_WIDTH = 2'd0,
    REG_MAX_WIDTH = 2'd1,
    REG_SYNC_MIN  = 2'd2,
    REG_SYNC_MAX  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_FRAME = 2'd0,
    EV_SYNC  = 2'd1,
    EV_DROP  = 2'd2,
    EV_ERROR = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_HIGH  = 2'd1,
    OP_LOW   = 2'd2
  } op_e;

  typedef struct packed {
    logic              pulse_level;
    logic [CountW-1:0] width_count;
  } item_t;

  typedef struct packed {
    event_e           event_kind;
    logic [CodeW-1:0] frame_code;
    logic [NumW-1:0]  frame_number;
    logic [BitsW-1:0] bits_received;
    logic             last_flag;
  } result_t;

  // Classified pulse handed from the front to the back end.
  typedef struct packed {
    op_e  op;
    logic is_sync;
    logic total_ok;
    logic bit_val;
  } token_t;

  // Results of one token, written to the result queue in the same cycle.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } res_wr_t;

endpackage

`default_nettype wire

### rtl/core/rrpcd_front.sv
// Front end: converts pulse widths to us, range-checks and classifies pulses.
// Holds the configuration registers. Depends on rrpcd_pkg.
`default_nettype none

module rrpcd_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire rrpcd_pkg::item_t      item_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [rrpcd_pkg::CfgW-1:0] cfg_wdata_i,
  output logic                       tok_push_o,
  output rrpcd_pkg::token_t          tok_o,
  input  wire logic                  tok_full_i
);

  localparam int unsigned CfgW   = rrpcd_pkg::CfgW;
  localparam int unsigned RatioW = rrpcd_pkg::RatioW;
  localparam int unsigned ProdW  = rrpcd_pkg::ProdW;
  localparam int unsigned UsW    = rrpcd_pkg::UsW;
  localparam int unsigned MulW   = rrpcd_pkg::CountW + 1 + 26;

  logic [CfgW-1:0]   min_w_q, max_w_q;
  logic [RatioW-1:0] sync_min_q, sync_max_q;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_level_q;
  logic [UsW-1:0]    s1_us_q;
  logic [MulW-1:0]   us_prod;

  logic [CfgW-1:0]   high_q;
  logic [ProdW-1:0]  prod_min, prod_max;

  logic              zero_w, out_range, s1_consume, accept;
  logic [CfgW-1:0]   low_us;
  logic [CfgW:0]     total, low_scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_w_q    <= rrpcd_pkg::MinWidthRst;
      max_w_q    <= rrpcd_pkg::MaxWidthRst;
      sync_min_q <= rrpcd_pkg::SyncMinRst;
      sync_max_q <= rrpcd_pkg::SyncMaxRst;
    end else if (cfg_we_i) begin
      unique case (rrpcd_pkg::cfg_reg_e'(cfg_idx_i))
        rrpcd_pkg::REG_MIN_WIDTH: min_w_q    <= cfg_wdata_i;
        rrpcd_pkg::REG_MAX_WIDTH: max_w_q    <= cfg_wdata_i;
        rrpcd_pkg::REG_SYNC_MIN:  sync_min_q <= cfg_wdata_i[RatioW-1:0];
        rrpcd_pkg::REG_SYNC_MAX:  sync_max_q <= cfg_wdata_i[RatioW-1:0];
        default: ;
      endcase
    end
  end

  // Convert counts to us by reciprocal multiply.
  assign us_prod = MulW'({item_i.width_count, 1'b0}) * MulW'(rrpcd_pkg::RecipUs);

  assign zero_w    = (s1_us_q == '0);
  assign out_range = (s1_us_q < UsW'(min_w_q)) || (s1_us_q > UsW'(max_w_q));
  assign low_us    = s1_us_q[CfgW-1:0];

  assign s1_consume = s1_valid_q && (zero_w || !tok_full_i);
  assign full_o     = s1_valid_q && !s1_consume;
  assign accept     = push_i && !full_o;
  assign s1_valid_d = accept || (s1_valid_q && !s1_consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_level_q <= item_i.pulse_level;
      s1_us_q    <= us_prod[rrpcd_pkg::RecipShift +: UsW];
    end
  end

  // Hold the last in-range high.
  always_ff @(posedge clk_i) begin
    if (tok_push_o && tok_o.op == rrpcd_pkg::OP_HIGH) begin
      high_q <= low_us;
    end
  end

  // Sync window bounds use the ratios in force when the low arrives.
  assign prod_min = ProdW'(sync_min_q) * ProdW'(high_q);
  assign prod_max = ProdW'(sync_max_q) * ProdW'(high_q);

  assign total      = (CfgW+1)'(high_q) + (CfgW+1)'(low_us);
  assign low_scaled = (CfgW+1)'(low_us) + (CfgW+1)'(low_us >> 1);

  always_comb begin
    tok_o.op       = rrpcd_pkg::OP_LOW;
    tok_o.is_sync  = (ProdW'(low_us) >= prod_min) && (ProdW'(low_us) <= prod_max);
    tok_o.total_ok = !((total < (CfgW+1)'(min_w_q)) || (total > (CfgW+1)'(max_w_q)));
    tok_o.bit_val  = ((CfgW+1)'(high_q) >= low_scaled);
    if (out_range) begin
      tok_o.op = rrpcd_pkg::OP_RESET;
    end else if (s1_level_q) begin
      tok_o.op = rrpcd_pkg::OP_HIGH;
    end
  end

  assign tok_push_o = s1_valid_q && !zero_w && !tok_full_i;

endmodule

`default_nettype wire

### rtl/core/rrpcd_tok_fifo.sv
// Short queue of classified pulses between the front and the back end.
// Depends on rrpcd_pkg.
`default_nettype none

module rrpcd_tok_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rrpcd_pkg::token_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output rrpcd_pkg::token_t      data_o
);

  localparam int unsigned Depth = rrpcd_pkg::TokDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rrpcd_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wp_q + 1'b1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rp_q + 1'b1);
      end
      cnt_q <= CntW'(cnt_q + CntW'(push_i) - CntW'(pop_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rrpcd_back.sv
// Back end: frame decoding state machine; turns pulse tokens into results.
// Depends on rrpcd_pkg.
`default_nettype none

module rrpcd_back #(
  parameter int unsigned FRAME_BITS = rrpcd_pkg::FrameBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tok_valid_i,
  input  wire rrpcd_pkg::token_t tok_i,
  output logic                   tok_pop_o,
  input  wire logic              res_space_i,
  output rrpcd_pkg::res_wr_t     res_wr_o
);

  localparam int unsigned CntW = $clog2(FRAME_BITS);
  localparam int unsigned NumW = rrpcd_pkg::NumW;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_WAIT   = 2'd1,
    PH_DECODE = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic                  held_q, held_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d, shift_nx;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [NumW-1:0]       frames_q, frames_d;
  rrpcd_pkg::result_t    res_a, res_b, blank;

  assign tok_pop_o = tok_valid_i && res_space_i;
  assign shift_nx  = {shift_q[FRAME_BITS-2:0], tok_i.bit_val};

  always_comb begin
    blank               = '0;
    blank.event_kind    = rrpcd_pkg::EV_FRAME;
    res_a               = blank;
    res_b               = blank;
    res_wr_o            = '0;
    phase_d             = phase_q;
    held_d              = held_q;
    shift_d             = shift_q;
    cnt_d               = cnt_q;
    frames_d            = frames_q;
    if (tok_pop_o) begin
      unique case (tok_i.op)
        rrpcd_pkg::OP_RESET: begin
          phase_d = PH_FIRST;
          held_d  = 1'b0;
          shift_d = '0;
          cnt_d   = '0;
        end
        rrpcd_pkg::OP_HIGH: begin
          held_d = 1'b1;
          if (phase_q == PH_FIRST) begin
            phase_d = PH_WAIT;
          end
        end
        rrpcd_pkg::OP_LOW: begin
          if (phase_q != PH_FIRST && held_q) begin
            held_d = 1'b0;
            if (tok_i.is_sync) begin
              phase_d = PH_DECODE;
              shift_d = '0;
              cnt_d   = '0;
              if (phase_q == PH_DECODE && cnt_q != '0) begin
                // Drop the partial frame, then report the sync.
                res_a.event_kind    = rrpcd_pkg::EV_DROP;
                res_a.bits_received = rrpcd_pkg::BitsW'(cnt_q);
                res_b.event_kind    = rrpcd_pkg::EV_SYNC;
                res_b.last_flag     = 1'b1;
                res_wr_o.num        = 2'd2;
              end else begin
                res_a.event_kind = rrpcd_pkg::EV_SYNC;
                res_a.last_flag  = 1'b1;
                res_wr_o.num     = 2'd1;
              end
            end else if (phase_q == PH_DECODE) begin
              if (!tok_i.total_ok) begin
                res_a.event_kind = rrpcd_pkg::EV_ERROR;
                res_a.last_flag  = 1'b1;
                res_wr_o.num     = 2'd1;
                phase_d          = PH_FIRST;
                shift_d          = '0;
                cnt_d            = '0;
              end else if (cnt_q == CntW'(FRAME_BITS - 1)) begin
                frames_d           = NumW'(frames_q + 1'b1);
                res_a.event_kind   = rrpcd_pkg::EV_FRAME;
                res_a.frame_code   = rrpcd_pkg::CodeW'(shift_nx);
                res_a.frame_number = frames_d;
                res_a.last_flag    = 1'b1;
                res_wr_o.num       = 2'd1;
                phase_d            = PH_FIRST;
                shift_d            = '0;
                cnt_d              = '0;
              end else begin
                shift_d = shift_nx;
                cnt_d   = CntW'(cnt_q + 1'b1);
              end
            end
          end
        end
        default: ;
      endcase
    end
    res_wr_o.first  = res_a;
    res_wr_o.second = res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      held_q   <= 1'b0;
      shift_q  <= '0;
      cnt_q    <= '0;
      frames_q <= '0;
    end else begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      shift_q  <= shift_d;
      cnt_q    <= cnt_d;
      frames_q <= frames_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rrpcd_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per pop.
// Depends on rrpcd_pkg.
`default_nettype none

module rrpcd_res_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rrpcd_pkg::res_wr_t wr_i,
  output logic                    space_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output rrpcd_pkg::result_t      data_o
);

  localparam int unsigned Depth = rrpcd_pkg::ResDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rrpcd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]    wp_q, rp_q;
  logic [CntW-1:0]    cnt_q;
  logic               do_pop;

  // Room for the worst case of two results from one transaction.
  assign space_o = (cnt_q <= CntW'(Depth - 2));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= PtrW'(wp_q + PtrW'(wr_i.num));
      rp_q  <= PtrW'(rp_q + PtrW'(do_pop));
      cnt_q <= CntW'(cnt_q + CntW'(wr_i.num) - CntW'(do_pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.num != 2'd0) begin
      mem_q[wp_q] <= wr_i.first;
    end
    if (wr_i.num == 2'd2) begin
      mem_q[PtrW'(wp_q + 1'b1)] <= wr_i.second;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rf_remote_pulse_code_decoder.sv
// Top level of the remote pulse code decoder: front, token queue, back end,
// result queue. Depends on rrpcd_pkg and the rrpcd_* modules.
//
// Usage:
//   Input channel: present a measured pulse on item_i and raise push_i; the
//   transaction completes at an edge where push_i is high and full_o is low.
//   Result channel: while empty_o is low the oldest result sits on result_o;
//   pop_i at such an edge takes it. A pulse yields zero, one or two results,
//   the last one marked by last_flag.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 min width, 1 max width, 2 sync ratio min, 3 sync ratio max) at once;
//   write only while the block is idle.
// Timing: a pulse is converted to microseconds in the input register stage,
//   classified from there into the token queue, and its results land in the
//   result queue when the back end takes its token; either queue can stall
//   these steps. One pulse per cycle is sustained while the result queue has
//   room; the single-step back end and the result pop rate set that figure.
// Reset: registers return to their defaults, the decoder to its first phase,
//   the frame count to zero, and both queues empty.
// Stall: when pop_i stays low the result queue fills, the back end holds,
//   the token queue fills, and full_o rises; nothing is lost.
`default_nettype none

module rf_remote_pulse_code_decoder #(
  parameter int unsigned FRAME_BITS = rrpcd_pkg::FrameBitsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire rrpcd_pkg::item_t           item_i,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output rrpcd_pkg::result_t              result_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [rrpcd_pkg::CfgW-1:0] cfg_wdata_i
);

  logic               tok_push, tok_full, tok_valid, tok_pop, res_space;
  rrpcd_pkg::token_t  tok_in, tok_out;
  rrpcd_pkg::res_wr_t res_wr;

  // Convert, range-check and classify each pulse.
  rrpcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tok_push_o  (tok_push),
    .tok_o       (tok_in),
    .tok_full_i  (tok_full)
  );

  // Decouple classification from decoding so each side stalls on its own.
  rrpcd_tok_fifo u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .valid_o (tok_valid),
    .data_o  (tok_out)
  );

  // Advance the frame state machine one token per cycle while the result queue has room.
  rrpcd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok_out),
    .tok_pop_o   (tok_pop),
    .res_space_i (res_space),
    .res_wr_o    (res_wr)
  );

  // Hold results until the receiver pops them.
  rrpcd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .space_o (res_space),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .data_o  (result_o)
  );

endmodule

`default_nettype wire
